// ----- rtl/core/gpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Gamepad packet parser package
// Shared types and constants: stick ring thresholds and angle reciprocals.
// ----------------------------------------------------------------------------
package gpp_pkg;

  // Ring boundaries on the stick byte; ring i+1 spans [RING_START[i], RING_START[i+1]).
  localparam logic [8:0] RING_START [8] = '{
    9'h004, 9'h010, 9'h024, 9'h040, 9'h064, 9'h090, 9'h0C4, 9'h100
  };

  localparam logic [5:0] RING_WIDTH [7] = '{
    6'd12, 6'd20, 6'd28, 6'd36, 6'd44, 6'd52, 6'd60
  };

  // 2*pi*4096 scaled by 2^20, then 2^16 more for the reciprocal.
  localparam logic [63:0] ANGLE_K_SH = 64'd26986075409 << 16;
  localparam int unsigned ANGLE_SHIFT = 36;

  // floor(ANGLE_K_SH / w) for each ring width
  localparam logic [47:0] ANGLE_RECIP [7] = '{
    48'(ANGLE_K_SH / 64'd12), 48'(ANGLE_K_SH / 64'd20), 48'(ANGLE_K_SH / 64'd28),
    48'(ANGLE_K_SH / 64'd36), 48'(ANGLE_K_SH / 64'd44), 48'(ANGLE_K_SH / 64'd52),
    48'(ANGLE_K_SH / 64'd60)
  };

  localparam int unsigned OUT_BITS  = 81;
  localparam int unsigned OUT_TDATA = 88;

  typedef struct packed {
    logic [2:0]         ring;
    logic signed [14:0] angle;
  } stick_t;

endpackage

// ----- rtl/core/gamepad_packet_parser_core.sv -----
// ----------------------------------------------------------------------------
// Gamepad packet parser core
// Decodes header-led gamepad packets and reports stick, trigger and button state.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis: link status, a byte-valid flag and the byte.
// Each beat is one step of the parser; a result beat leaves on m_axis when a
// packet completes (including an empty header) or when the link drops while it
// was up. Most input beats produce no result.
// Timing: a beat is registered in the input register when taken, decoded from
// there (ring compare and one constant multiply for the stick angle) and its
// result is registered in the result register that drives m_axis_tvalid. One
// beat per cycle is sustained while m_axis_tready is high.
// Stall: while a result waits unaccepted, the beat in the input register is
// held and s_axis_tready drops once that register is full.
// Reset: all parser state clears (no link seen, expecting a header, sticks,
// triggers and buttons zero); both channels come up empty.
// ----------------------------------------------------------------------------
module gamepad_packet_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // link_up, byte_valid, rx_byte[7:0], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // right_ring, right_angle, left_ring, left_angle,
                                     // right_pull, left_pull, pad_bits, button_bits,
                                     // pressed_mask, released_mask, is_connected, pad
);
  import gpp_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'b01,
    PH_PAYLOAD = 2'b10
  } phase_e;

  typedef enum logic [2:0] {
    SEC_RSTICK = 3'd0,
    SEC_LSTICK = 3'd1,
    SEC_TRIG   = 3'd2,
    SEC_PAD    = 3'd3,
    SEC_BTN    = 3'd4
  } sect_e;

  // input register
  logic       in_valid_q, in_valid_d;
  logic       in_link_q, in_bvalid_q;
  logic [7:0] in_byte_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [4:0]  pending_q, pending_d;
  logic        link_seen_q, link_seen_d;
  logic [5:0]  rings_q, rings_d;
  logic [29:0] angles_q, angles_d;
  logic [7:0]  trig_q, trig_d;
  logic [11:0] held_q, held_d;
  logic [11:0] prev_q, prev_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0] out_q, res;

  logic   out_ready, proc_fire, s_fire, emit, conn;
  sect_e  sec;
  stick_t stick;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign proc_fire     = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  gpp_stick_decode u_stick (
    .byte_i  (in_byte_q),
    .stick_o (stick)
  );

  always_comb begin
    if (pending_q[0])      sec = SEC_RSTICK;
    else if (pending_q[1]) sec = SEC_LSTICK;
    else if (pending_q[2]) sec = SEC_TRIG;
    else if (pending_q[3]) sec = SEC_PAD;
    else                   sec = SEC_BTN;
  end

  always_comb begin
    phase_d     = phase_q;
    pending_d   = pending_q;
    link_seen_d = link_seen_q;
    rings_d     = rings_q;
    angles_d    = angles_q;
    trig_d      = trig_q;
    held_d      = held_q;
    prev_d      = prev_q;
    emit        = 1'b0;
    conn        = 1'b1;

    if (!in_link_q) begin
      if (link_seen_q) begin
        // link drop: abandon packet, clear inputs, report edges once
        link_seen_d = 1'b0;
        phase_d     = PH_HEADER;
        pending_d   = 5'd0;
        rings_d     = 6'd0;
        angles_d    = 30'd0;
        trig_d      = 8'd0;
        prev_d      = held_q;
        held_d      = 12'd0;
        emit        = 1'b1;
        conn        = 1'b0;
      end
    end else begin
      link_seen_d = 1'b1;
      if (in_bvalid_q) begin
        case (phase_q)
          PH_HEADER: begin
            pending_d = in_byte_q[4:0];
            if (in_byte_q[4:0] == 5'd0) emit = 1'b1;
            else                        phase_d = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            pending_d = pending_q & ~(5'd1 << sec);
            case (sec)
              SEC_RSTICK: begin
                rings_d[2:0]   = stick.ring;
                angles_d[14:0] = stick.angle;
              end
              SEC_LSTICK: begin
                rings_d[5:3]    = stick.ring;
                angles_d[29:15] = stick.angle;
              end
              SEC_TRIG: trig_d = in_byte_q;
              SEC_PAD: begin
                prev_d[3:0] = held_q[3:0];
                held_d[3:0] = in_byte_q[3:0];
              end
              SEC_BTN: begin
                prev_d[11:4] = held_q[11:4];
                held_d[11:4] = in_byte_q;
              end
              default: ;
            endcase
            if (pending_d == 5'd0) begin
              phase_d = PH_HEADER;
              emit    = 1'b1;
            end
          end
          default: phase_d = PH_HEADER;
        endcase
      end
    end

    res = {conn, prev_d & ~held_d, held_d & ~prev_d, held_d[11:4], held_d[3:0],
           trig_d[7:4], trig_d[3:0], angles_d[29:15], rings_d[5:3],
           angles_d[14:0], rings_d[2:0]};
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire)         in_valid_d = 1'b1;
    else if (proc_fire) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready) out_valid_d = proc_fire && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      pending_q   <= 5'd0;
      link_seen_q <= 1'b0;
      rings_q     <= 6'd0;
      angles_q    <= 30'd0;
      trig_q      <= 8'd0;
      held_q      <= 12'd0;
      prev_q      <= 12'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc_fire) begin
        phase_q     <= phase_d;
        pending_q   <= pending_d;
        link_seen_q <= link_seen_d;
        rings_q     <= rings_d;
        angles_q    <= angles_d;
        trig_q      <= trig_d;
        held_q      <= held_d;
        prev_q      <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_link_q   <= s_axis_tdata[0];
      in_bvalid_q <= s_axis_tdata[1];
      in_byte_q   <= s_axis_tdata[9:2];
    end
    if (proc_fire && emit) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q};

  // ---- assertions ----
  a_phase_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) == (pending_q != 5'd0))
    else $error("pending sections disagree with parse phase");

  a_drop_clears_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && emit && !conn |=> !link_seen_q && phase_q == PH_HEADER)
    else $error("link drop result without state clear");

  a_edges_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q[67:56] & out_q[79:68]) == 12'd0)
    else $error("press and release on the same bit");

  a_drop_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q[80] |-> out_q[55:0] == 56'd0)
    else $error("link drop result carries stale inputs");

  a_stall_holds_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_ready |=> in_valid_q && $stable(in_byte_q))
    else $error("input beat lost while output stalled");

endmodule

// ----- rtl/core/gpp_stick_decode.sv -----
// ----------------------------------------------------------------------------
// Stick byte decoder
// Maps one stick byte to a radius ring and a Q3.12 angle within that ring.
// ----------------------------------------------------------------------------
module gpp_stick_decode (
  input  logic [7:0]      byte_i,
  output gpp_pkg::stick_t stick_o
);
  import gpp_pkg::*;

  logic [2:0]  ring_idx;
  logic [8:0]  diff;
  logic [5:0]  offset;
  logic [5:0]  width;
  logic        neg;
  logic [4:0]  mag;
  logic [52:0] prod;
  logic [52:0] rounded;
  logic [13:0] q;

  always_comb begin
    ring_idx = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if ({1'b0, byte_i} >= RING_START[i]) ring_idx = 3'(i);
    end
    width  = RING_WIDTH[ring_idx];
    diff   = {1'b0, byte_i} - RING_START[ring_idx];
    offset = diff[5:0];
    // upper half of the ring wraps to a negative angle
    neg    = {offset, 1'b0} > {1'b0, width};
    mag    = neg ? 5'(width - offset) : offset[4:0];
    prod    = {48'd0, mag} * {5'd0, ANGLE_RECIP[ring_idx]};
    rounded = prod + (53'd1 << (ANGLE_SHIFT - 1));
    q       = rounded[ANGLE_SHIFT +: 14];

    if ({1'b0, byte_i} < RING_START[0]) begin
      stick_o.ring  = 3'd0;
      stick_o.angle = 15'sd0;
    end else begin
      stick_o.ring  = ring_idx + 3'd1;
      stick_o.angle = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

endmodule

// ----- dv/gamepad_packet_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// Gamepad packet parser core testbench
// Streams link/byte beats into the parser: a directed opening, then random
// packets with mid-packet link drops and noise. Expected reports come from a
// behavioural model of the parser and are checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamepad_packet_parser_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TARGET_BEATS = 1475;
  localparam int unsigned PHASE_BEATS  = 190;

  localparam int RING_EDGE [8] = '{4, 16, 36, 64, 100, 144, 196, 256};
  localparam longint unsigned TWO_PI_Q = 64'd26986075409;  // 2*pi*4096 * 2^20

  // Report fields, lowest bit up
  localparam int NUM_FIELDS = 11;
  localparam int F_LSB [NUM_FIELDS] = '{0, 3, 18, 21, 36, 40, 44, 48, 56, 68, 80};
  localparam int F_WID [NUM_FIELDS] = '{3, 15, 3, 15, 4, 4, 4, 8, 12, 12, 1};
  localparam string F_NAME [NUM_FIELDS] = '{
    "right_ring", "right_angle", "left_ring", "left_angle", "right_pull", "left_pull",
    "pad_bits", "button_bits", "pressed_mask", "released_mask", "is_connected"
  };

  typedef struct {
    logic       up;
    logic       valid;
    logic [7:0] data;
    bit         hold;   // wait for every outstanding report before sending
  } beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // link_up, byte_valid, rx_byte[7:0], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;   // right_ring, right_angle, left_ring, left_angle, right_pull,
                               // left_pull, pad_bits, button_bits, pressed_mask,
                               // released_mask, is_connected, pad

  gamepad_packet_parser_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  beat_t       beat_q [$];
  logic [87:0] report_q [$];
  int unsigned errors;
  int unsigned sent;
  int unsigned cycles;
  int unsigned useful_n;
  bit          gen_link;
  bit          hold_next;
  bit          beat_taken;

  // Parser model state
  bit          in_packet;
  logic [4:0]  sections_left;
  bit          link_was_up;
  logic [2:0]  r_ring, l_ring;
  logic [14:0] r_ang, l_ang;
  logic [7:0]  trig;
  logic [11:0] held_now, held_prev;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void decode_stick(input logic [7:0] b, output logic [2:0] ring,
                                       output logic [14:0] ang);
    longint unsigned num, den, q;
    int r, w, n;
    bit neg;
    neg = 1'b0;
    if (b < RING_EDGE[0]) begin
      ring = 3'd0;
      ang  = 15'd0;
      return;
    end
    r = 0;
    while (r < 6 && b >= RING_EDGE[r + 1]) r++;
    w = RING_EDGE[r + 1] - RING_EDGE[r];
    n = b - RING_EDGE[r];
    // upper half of a ring wraps to a negative angle
    if (2 * n > w) begin
      n   = w - n;
      neg = 1'b1;
    end
    num  = 64'(2 * n) * TWO_PI_Q + (64'(w) << 20);
    den  = 64'(w) << 21;
    q    = num / den;
    ring = 3'(r + 1);
    ang  = neg ? 15'(-q[14:0]) : q[14:0];
  endfunction

  function automatic logic [87:0] make_report(input logic conn);
    return {7'd0, conn, held_prev & ~held_now, held_now & ~held_prev, held_now[11:4],
            held_now[3:0], trig[7:4], trig[3:0], l_ang, l_ring, r_ang, r_ring};
  endfunction

  // One accepted beat through the parser model; queues a report if one is due.
  task automatic advance_parser(input logic up, input logic valid, input logic [7:0] b);
    int sec;
    if (!up) begin
      if (link_was_up) begin
        link_was_up   = 1'b0;
        in_packet     = 1'b0;
        sections_left = '0;
        r_ring = '0; l_ring = '0; r_ang = '0; l_ang = '0; trig = '0;
        held_prev = held_now;
        held_now  = '0;
        report_q.push_back(make_report(1'b0));
      end
      return;
    end
    link_was_up = 1'b1;
    if (!valid) return;
    if (!in_packet) begin
      sections_left = b[4:0];
      if (sections_left == 5'd0) report_q.push_back(make_report(1'b1));
      else in_packet = 1'b1;
      return;
    end
    sec = 0;
    while (sec < 4 && !sections_left[sec]) sec++;
    sections_left[sec] = 1'b0;
    case (sec)
      0: decode_stick(b, r_ring, r_ang);
      1: decode_stick(b, l_ring, l_ang);
      2: trig = b;
      3: begin
        held_prev[3:0] = held_now[3:0];
        held_now[3:0]  = b[3:0];
      end
      default: begin
        held_prev[11:4] = held_now[11:4];
        held_now[11:4]  = b;
      end
    endcase
    if (sections_left == 5'd0) begin
      in_packet = 1'b0;
      report_q.push_back(make_report(1'b1));
    end
  endtask

  task automatic push_beat(input logic up, input logic valid, input logic [7:0] data);
    beat_t b;
    b.up    = up;
    b.valid = valid;
    b.data  = data;
    b.hold  = hold_next;
    hold_next = 1'b0;
    // repeated link-down beats do nothing and are not counted
    if (up || gen_link) useful_n++;
    gen_link = up;
    beat_q.push_back(b);
  endtask

  function automatic logic [7:0] stick_byte();
    int e;
    if ($urandom_range(3) != 0) return 8'($urandom_range(255));
    e = RING_EDGE[$urandom_range(6)] - $urandom_range(1);
    return 8'(e);
  endfunction

  task automatic add_packet();
    logic [7:0] hdr;
    int k;
    hdr = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) hdr[4:0] = 5'd0;
    else if ($urandom_range(3) == 0) hdr[4:0] = 5'h1F;
    push_beat(1'b1, 1'b1, hdr);
    for (k = 0; k < 5; k++) begin
      if (hdr[k]) begin
        if ($urandom_range(9) == 0) push_beat(1'b1, 1'b0, 8'($urandom_range(255)));
        if ($urandom_range(49) == 0) begin
          // link lost part way through the packet
          push_beat(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
          return;
        end
        push_beat(1'b1, 1'b1, (k < 2) ? stick_byte() : 8'($urandom_range(255)));
      end
    end
  endtask

  function automatic int idle_pct(input int unsigned n);
    case ((n / PHASE_BEATS) % 4)
      1:       return 82;
      3:       return 28;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct(input int unsigned n);
    case ((n / PHASE_BEATS) % 4)
      2:       return 82;
      3:       return 28;
      default: return 0;
    endcase
  endfunction

  // Driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct(sent));
      if (!s_axis_tvalid || beat_taken) begin
        if (beat_q.size() == 0 || (beat_q[0].hold && report_q.size() != 0) ||
            $urandom_range(99) < idle_pct(sent)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, beat_q[0].data, beat_q[0].valid, beat_q[0].up};
          beat_q.pop_front();
          sent++;
        end
      end
    end
  end

  // Monitor and checker
  always @(posedge clk_i) begin
    logic [87:0] want;
    int f;
    beat_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = report_q.pop_front();
        for (f = 0; f < NUM_FIELDS; f++) begin
          if (((want >> F_LSB[f]) & ((88'd1 << F_WID[f]) - 1)) !=
              ((m_axis_tdata >> F_LSB[f]) & ((88'd1 << F_WID[f]) - 1))) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, F_NAME[f],
                     (want >> F_LSB[f]) & ((88'd1 << F_WID[f]) - 1),
                     (m_axis_tdata >> F_LSB[f]) & ((88'd1 << F_WID[f]) - 1));
          end
        end
      end
    end
    if (rst_ni && beat_taken)
      advance_parser(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[9:2]);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int sel;
    int k;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    errors = 0; sent = 0; cycles = 0; useful_n = 0;
    gen_link = 1'b0; hold_next = 1'b0; beat_taken = 1'b0;
    in_packet = 1'b0; sections_left = '0; link_was_up = 1'b0;
    r_ring = '0; l_ring = '0; r_ang = '0; l_ang = '0; trig = '0;
    held_now = '0; held_prev = '0;

    // directed opening
    push_beat(1'b0, 1'b1, 8'h1F);          // link never up: ignored
    push_beat(1'b1, 1'b0, 8'hA5);          // link up, no byte
    push_beat(1'b1, 1'b1, 8'h00);          // empty header
    push_beat(1'b1, 1'b1, 8'hE0);          // empty header, top bits set
    push_beat(1'b1, 1'b1, 8'h1F);          // every section present
    push_beat(1'b1, 1'b1, 8'h00);
    push_beat(1'b1, 1'b1, 8'hFF);
    push_beat(1'b1, 1'b1, 8'hFF);
    push_beat(1'b1, 1'b1, 8'h0F);
    push_beat(1'b1, 1'b1, 8'hFF);
    push_beat(1'b1, 1'b1, 8'hFF);          // every section again, all released
    push_beat(1'b1, 1'b1, 8'h04);
    push_beat(1'b1, 1'b1, 8'h03);
    push_beat(1'b1, 1'b1, 8'h00);
    push_beat(1'b1, 1'b1, 8'hF0);
    push_beat(1'b1, 1'b1, 8'h00);
    push_beat(1'b1, 1'b1, 8'h03);          // half-ring point and just past it
    push_beat(1'b1, 1'b1, 8'h0A);
    push_beat(1'b1, 1'b1, 8'h0B);
    push_beat(1'b1, 1'b1, 8'h03);          // ring boundaries
    push_beat(1'b1, 1'b1, 8'h10);
    push_beat(1'b1, 1'b1, 8'h0F);
    push_beat(1'b1, 1'b1, 8'h18);          // d-pad then link drop mid-packet
    push_beat(1'b1, 1'b1, 8'h05);
    push_beat(1'b0, 1'b0, 8'h00);
    push_beat(1'b0, 1'b1, 8'h7E);          // link still down
    hold_next = 1'b1;
    push_beat(1'b1, 1'b0, 8'h00);

    while (useful_n < TARGET_BEATS) begin
      sel = $urandom_range(99);
      if ($urandom_range(249) == 0) hold_next = 1'b1;
      if (sel < 85) begin
        add_packet();
      end else if (sel < 91) begin
        push_beat(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
        for (k = $urandom_range(3); k > 0; k--)
          push_beat(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        push_beat(1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (beat_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && report_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
